/* design/nearest_centroid_colorizer_core_macros.svh */
// Assertion macros for the nearest centroid colorizer checker.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef NEAREST_CENTROID_COLORIZER_CORE_MACROS_SVH
`define NEAREST_CENTROID_COLORIZER_CORE_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define NCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/ncc_pkg.sv */
// Shared types, constants and the hue table of the nearest centroid colorizer.
// Depends on nothing.
package ncc_pkg;

  localparam int CNT_W     = 4;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 32;
  localparam int CH_W      = 8;
  localparam int CL_W      = 3;
  localparam int SLOT_W    = 3;
  localparam int SV_W      = 14;
  localparam int K_W       = 6;
  localparam int X_W       = 20;
  localparam int Z_W       = 24;
  localparam int RECIP_W   = 17;
  localparam int P_W       = Z_W + RECIP_W;
  localparam int RECIP_SH  = 32;

  localparam logic [PCT_W-1:0]     PCT_MAX     = 7'd100;
  localparam logic [PCT_W-1:0]     PCT_RESET   = 7'd100;
  // Channel = floor(17 * x / 40000); the reciprocal is floor(2^32 / 40000).
  localparam logic [Z_W-1:0]       DEN         = 24'd40000;
  localparam logic [RECIP_W-1:0]   RECIP       = 17'd107374;

  localparam logic                 ACT_LOAD     = 1'b0;
  localparam logic                 ACT_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

  typedef struct packed {
    logic               action;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] coord_a;
    logic [COORD_W-1:0] coord_b;
    logic [COORD_W-1:0] coord_c;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CL_W-1:0]  cluster;
    logic             no_centroid;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [POS_W-1:0] out_z;
  } out_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [CNT_W-1:0] idx;
  } rd_ctl_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    sector_t        sector;
    logic [K_W-1:0] k;
  } hue_t;

  // Hue 360 / (index + 1) reduced to its 60 degree sector and ramp weight.
  function automatic hue_t hue_lookup(input logic [CNT_W-1:0] best);
    hue_t h;
    h.sector = SEC_RED_YEL;
    h.k      = '0;
    unique case (best)
      4'd0:  begin h.sector = SEC_MAG_RED; h.k = 6'd0;  end
      4'd1:  begin h.sector = SEC_CYN_BLU; h.k = 6'd60; end
      4'd2:  begin h.sector = SEC_GRN_CYN; h.k = 6'd0;  end
      4'd3:  begin h.sector = SEC_YEL_GRN; h.k = 6'd30; end
      4'd4:  begin h.sector = SEC_YEL_GRN; h.k = 6'd48; end
      4'd5:  begin h.sector = SEC_YEL_GRN; h.k = 6'd60; end
      4'd6:  begin h.sector = SEC_RED_YEL; h.k = 6'd51; end
      4'd7:  begin h.sector = SEC_RED_YEL; h.k = 6'd45; end
      4'd8:  begin h.sector = SEC_RED_YEL; h.k = 6'd40; end
      4'd9:  begin h.sector = SEC_RED_YEL; h.k = 6'd36; end
      4'd10: begin h.sector = SEC_RED_YEL; h.k = 6'd32; end
      4'd11: begin h.sector = SEC_RED_YEL; h.k = 6'd30; end
      4'd12: begin h.sector = SEC_RED_YEL; h.k = 6'd27; end
      4'd13: begin h.sector = SEC_RED_YEL; h.k = 6'd25; end
      4'd14: begin h.sector = SEC_RED_YEL; h.k = 6'd24; end
      4'd15: begin h.sector = SEC_RED_YEL; h.k = 6'd22; end
    endcase
    return h;
  endfunction

endpackage

/* design/nearest_centroid_colorizer_core.sv */
// Nearest centroid colorizer top level: configuration, sequencer, centroid RAM.
// Depends on ncc_pkg, ncc_ram, ncc_search and ncc_color.
// A load transfer is accepted while idle and busy stays low. A classify transfer with searched
// centroids reads the centroid RAM, one centroid read per cycle, then the search and color
// pipelines run; busy stays high until the result strobes, when the next item can be taken.
// With no centroid searched the result strobes the next cycle and busy stays low.
// Synchronous reset clears control and configuration; the centroid table is not cleared.
module nearest_centroid_colorizer_core #(
  parameter int MAX_CENTROIDS = 8,
  parameter int COORD_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ncc_pkg::in_t                      in_data,
  output logic                              out_strobe,
  output ncc_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [ncc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ncc_pkg::PCT_W-1:0]         cfg_wdata
);

  localparam int CW = (COORD_BITS < ncc_pkg::COORD_W) ? COORD_BITS : ncc_pkg::COORD_W;
  localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int EW = 3 * CW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ncc_pkg::CNT_W-1:0]     cnt_r;
  logic [ncc_pkg::PCT_W-1:0]     sat_r;
  logic [ncc_pkg::PCT_W-1:0]     bri_r;
  logic [ncc_pkg::PCT_W-1:0]     s_sat;
  logic [ncc_pkg::PCT_W-1:0]     v_sat;
  logic [ncc_pkg::SV_W-1:0]      s_ext;
  logic [ncc_pkg::SV_W-1:0]      v_ext;
  logic [ncc_pkg::SV_W-1:0]      sv_r;
  logic [ncc_pkg::SV_W-1:0]      vm_r;
  logic [ncc_pkg::CNT_W-1:0]     n_cnt;
  logic [ncc_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [ncc_pkg::CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  ncc_pkg::rd_ctl_t              rd_ctl_r, rd_ctl_nxt;
  logic [2:0][CW-1:0]            pt_r, pt_nxt;
  logic [ncc_pkg::POS_W-1:0]     px_r, py_r, pz_r;
  logic                          out_valid_r, out_valid_nxt;
  ncc_pkg::out_t                 out_data_r, out_data_nxt;
  logic                          acc;
  logic                          is_cls;
  logic                          last_rd;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [2:0][CW-1:0]            ram_wdata;
  logic [EW-1:0]                 ram_rdata;
  logic [2:0][CW-1:0]            entry;
  logic [ncc_pkg::CNT_W-1:0]     best;
  logic                          srch_done;
  logic [2:0][ncc_pkg::CH_W-1:0] rgb;
  logic                          col_vld;

  // Configuration registers and the saturation/value products they imply.
  assign s_sat = (sat_r > ncc_pkg::PCT_MAX) ? ncc_pkg::PCT_MAX : sat_r;
  assign v_sat = (bri_r > ncc_pkg::PCT_MAX) ? ncc_pkg::PCT_MAX : bri_r;
  assign s_ext = ncc_pkg::SV_W'(s_sat);
  assign v_ext = ncc_pkg::SV_W'(v_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sat_r <= ncc_pkg::PCT_RESET;
      bri_r <= ncc_pkg::PCT_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == ncc_pkg::REG_COUNT) begin
        cnt_r <= cfg_wdata[ncc_pkg::CNT_W-1:0];
      end
      if (cfg_idx == ncc_pkg::REG_SATURATION) begin
        sat_r <= cfg_wdata;
      end
      if (cfg_idx == ncc_pkg::REG_BRIGHTNESS) begin
        bri_r <= cfg_wdata;
      end
    end
    sv_r <= s_ext * v_ext;
    vm_r <= v_ext * ncc_pkg::SV_W'(ncc_pkg::PCT_MAX - s_sat);
  end

  assign n_cnt = (32'(cnt_r) > MAX_CENTROIDS) ? ncc_pkg::CNT_W'(MAX_CENTROIDS) : cnt_r;

  assign busy    = (state_r != ST_IDLE);
  assign acc     = start && !busy;
  assign is_cls  = (in_data.action == ncc_pkg::ACT_CLASSIFY);
  assign last_rd = (rd_idx_r == (n_r - ncc_pkg::CNT_W'(1)));

  assign ram_we       = acc && !is_cls && (32'(in_data.slot) < MAX_CENTROIDS);
  assign ram_waddr    = AW'(in_data.slot);
  assign ram_wdata[0] = in_data.coord_a[CW-1:0];
  assign ram_wdata[1] = in_data.coord_b[CW-1:0];
  assign ram_wdata[2] = in_data.coord_c[CW-1:0];
  assign ram_raddr    = AW'(rd_idx_r);
  assign entry        = ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    rd_ctl_nxt    = '0;
    pt_nxt        = pt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && is_cls) begin
          pt_nxt = ram_wdata;
          if (n_cnt == '0) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt             = '0;
            out_data_nxt.no_centroid = 1'b1;
            out_data_nxt.out_x       = in_data.pos_x;
            out_data_nxt.out_y       = in_data.pos_y;
            out_data_nxt.out_z       = in_data.pos_z;
          end else begin
            state_nxt  = ST_SEARCH;
            n_nxt      = n_cnt;
            rd_idx_nxt = '0;
          end
        end
      end
      ST_SEARCH: begin
        rd_ctl_nxt.vld  = 1'b1;
        rd_ctl_nxt.last = last_rd;
        rd_ctl_nxt.idx  = rd_idx_r;
        rd_idx_nxt      = rd_idx_r + ncc_pkg::CNT_W'(1);
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (col_vld) begin
          state_nxt                = ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.red         = rgb[0];
          out_data_nxt.green       = rgb[1];
          out_data_nxt.blue        = rgb[2];
          out_data_nxt.cluster     = best[ncc_pkg::CL_W-1:0];
          out_data_nxt.no_centroid = 1'b0;
          out_data_nxt.out_x       = px_r;
          out_data_nxt.out_y       = py_r;
          out_data_nxt.out_z       = pz_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ctl_r    <= rd_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pt_r       <= pt_nxt;
    out_data_r <= out_data_nxt;
    if (acc) begin
      px_r <= in_data.pos_x;
      py_r <= in_data.pos_y;
      pz_r <= in_data.pos_z;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

  ncc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CENTROIDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ncc_search #(
    .CW (CW)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_ctl (rd_ctl_r),
    .entry  (entry),
    .pt     (pt_r),
    .best   (best),
    .done   (srch_done)
  );

  ncc_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (srch_done),
    .best  (best),
    .sv    (sv_r),
    .vm    (vm_r),
    .rgb   (rgb),
    .vld   (col_vld)
  );

endmodule

/* design/ncc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ncc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/ncc_search.sv */
// Distance and running minimum pipeline over centroid table entries.
// Depends on ncc_pkg for the read control struct and count width.
module ncc_search #(
  parameter int CW = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ncc_pkg::rd_ctl_t             rd_ctl,
  input  logic [2:0][CW-1:0]           entry,
  input  logic [2:0][CW-1:0]           pt,
  output logic [ncc_pkg::CNT_W-1:0]    best,
  output logic                         done
);

  localparam int SQ_W = 2 * CW;
  localparam int DW   = SQ_W + 2;

  logic [2:0][SQ_W-1:0]       sq_nxt;
  logic [2:0][SQ_W-1:0]       sq_r;
  ncc_pkg::rd_ctl_t           s1_ctl_r;
  logic [DW-1:0]              sum;
  logic [DW-1:0]              best_d_r;
  logic [ncc_pkg::CNT_W-1:0]  best_r;
  logic                       done_r;
  logic                       upd;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [CW-1:0]   diff;
    logic [SQ_W-1:0] d_ext;
    assign diff       = (pt[j] > entry[j]) ? (pt[j] - entry[j]) : (entry[j] - pt[j]);
    assign d_ext      = SQ_W'(diff);
    assign sq_nxt[j]  = d_ext * d_ext;
  end

  assign sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
  assign upd = s1_ctl_r.vld && ((s1_ctl_r.idx == '0) || (sum < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      done_r   <= 1'b0;
    end else begin
      s1_ctl_r <= rd_ctl;
      done_r   <= s1_ctl_r.vld && s1_ctl_r.last;
    end
    sq_r <= sq_nxt;
    if (upd) begin
      best_r   <= s1_ctl_r.idx;
      best_d_r <= sum;
    end
  end

  assign best = best_r;
  assign done = done_r;

endmodule

/* design/ncc_color.sv */
// HSV to RGB pipeline: sector parts, reciprocal scaling, and correction.
// Depends on ncc_pkg for the hue table and scaling constants.
module ncc_color (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [ncc_pkg::CNT_W-1:0]         best,
  input  logic [ncc_pkg::SV_W-1:0]          sv,
  input  logic [ncc_pkg::SV_W-1:0]          vm,
  output logic [2:0][ncc_pkg::CH_W-1:0]     rgb,
  output logic                              vld
);

  ncc_pkg::hue_t                        hue;
  logic [ncc_pkg::X_W-1:0]              sv_x;
  logic [ncc_pkg::X_W-1:0]              vm_x;
  logic [ncc_pkg::X_W-1:0]              pc;
  logic [ncc_pkg::X_W-1:0]              px;
  logic [ncc_pkg::X_W-1:0]              pm;
  logic [2:0][ncc_pkg::X_W-1:0]         part;
  logic [2:0][ncc_pkg::X_W-1:0]         x_r;
  logic [2:0][ncc_pkg::Z_W-1:0]         z_nxt;
  logic [2:0][ncc_pkg::Z_W-1:0]         z_r;
  logic [2:0][ncc_pkg::CH_W-1:0]        q0_nxt;
  logic [2:0][ncc_pkg::CH_W-1:0]        q0_r;
  logic [2:0][ncc_pkg::CH_W-1:0]        q_nxt;
  logic [2:0][ncc_pkg::CH_W-1:0]        rgb_r;
  logic                                 v1_r;
  logic                                 v2_r;
  logic                                 v3_r;

  assign hue  = ncc_pkg::hue_lookup(best);
  assign sv_x = ncc_pkg::X_W'(sv);
  assign vm_x = ncc_pkg::X_W'(vm);
  assign pc   = (sv_x << 6) - (sv_x << 2);
  assign px   = ncc_pkg::X_W'(hue.k) * sv_x;
  assign pm   = (vm_x << 6) - (vm_x << 2);

  always_comb begin
    part = '0;
    unique case (hue.sector)
      ncc_pkg::SEC_RED_YEL: begin part[0] = pc; part[1] = px; end
      ncc_pkg::SEC_YEL_GRN: begin part[0] = px; part[1] = pc; end
      ncc_pkg::SEC_GRN_CYN: begin part[1] = pc; part[2] = px; end
      ncc_pkg::SEC_CYN_BLU: begin part[1] = px; part[2] = pc; end
      ncc_pkg::SEC_BLU_MAG: begin part[0] = px; part[2] = pc; end
      ncc_pkg::SEC_MAG_RED: begin part[0] = pc; part[2] = px; end
      default:              begin part    = '0; end
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [ncc_pkg::P_W-1:0] prod;
    logic [ncc_pkg::Z_W-1:0] rem;
    assign z_nxt[c]  = (ncc_pkg::Z_W'(x_r[c]) << 4) + ncc_pkg::Z_W'(x_r[c]);
    assign prod      = ncc_pkg::P_W'(z_nxt[c]) * ncc_pkg::P_W'(ncc_pkg::RECIP);
    assign q0_nxt[c] = prod[ncc_pkg::RECIP_SH +: ncc_pkg::CH_W];
    assign rem       = z_r[c] - ncc_pkg::Z_W'(q0_r[c]) * ncc_pkg::DEN;
    assign q_nxt[c]  = q0_r[c] + ncc_pkg::CH_W'(rem >= ncc_pkg::DEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    for (int c = 0; c < 3; c++) begin
      x_r[c] <= part[c] + pm;
    end
    z_r   <= z_nxt;
    q0_r  <= q0_nxt;
    rgb_r <= q_nxt;
  end

  assign rgb = rgb_r;
  assign vld = v3_r;

endmodule

/* design/ncc_checker.sv */
// Port-level checks of the colorizer handshake and result rules, bound to the top level.
// Depends on ncc_pkg and nearest_centroid_colorizer_core_macros.svh.
`include "nearest_centroid_colorizer_core_macros.svh"

module ncc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ncc_pkg::in_t  in_data,
  input logic          out_strobe,
  input ncc_pkg::out_t out_data
);

  `NCC_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobe while busy")

  `NCC_ASSERT_NEXT(a_load_silent, start && !busy && (in_data.action == ncc_pkg::ACT_LOAD), !out_strobe && !busy, "load transfer produced a result or stalled")

  `NCC_ASSERT_NEXT(a_cls_progress, start && !busy && (in_data.action == ncc_pkg::ACT_CLASSIFY), busy || out_strobe, "classify transfer neither started nor finished")

  `NCC_ASSERT_NOW(a_empty_black, out_strobe && out_data.no_centroid, (out_data.red == '0) && (out_data.green == '0) && (out_data.blue == '0) && (out_data.cluster == '0), "empty result is not black")

endmodule

bind nearest_centroid_colorizer_core ncc_checker u_ncc_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for nearest_centroid_colorizer_core: load and classify transfers,
// palette settings at their extremes, then bursty random traffic checked against a local
// predictor. Depends on ncc_pkg and the core RTL only.
module testbench;

  localparam int NUM_SLOTS = 8;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  ncc_pkg::in_t                  in_data = '0;
  logic                          out_strobe;
  ncc_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [ncc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ncc_pkg::PCT_W-1:0]     cfg_wdata = '0;

  logic [ncc_pkg::COORD_W-1:0] centroid_tab [NUM_SLOTS][3];
  logic [ncc_pkg::CNT_W-1:0]   count_reg = '0;
  logic [ncc_pkg::PCT_W-1:0]   sat_reg = ncc_pkg::PCT_RESET;
  logic [ncc_pkg::PCT_W-1:0]   bright_reg = ncc_pkg::PCT_RESET;
  ncc_pkg::out_t               pending_colors[$];
  int unsigned                 mismatch_count = 0;

  nearest_centroid_colorizer_core #(
    .MAX_CENTROIDS(NUM_SLOTS),
    .COORD_BITS(ncc_pkg::COORD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [ncc_pkg::CH_W-1:0] scale_channel(longint unsigned part,
                                                             longint unsigned offset);
    longint unsigned c;
    c = (64'd255 * (part + offset)) / 64'd600000;
    return (c > 64'd255) ? 8'd255 : c[ncc_pkg::CH_W-1:0];
  endfunction

  function automatic ncc_pkg::out_t classify_point(ncc_pkg::in_t item);
    ncc_pkg::out_t               r;
    logic [ncc_pkg::COORD_W-1:0] pt [3];
    int unsigned                 n, best;
    longint unsigned             sq_dist, best_dist, diff, s, v, hue, t, k, pc, px, pm;
    logic [ncc_pkg::CH_W-1:0]    c_ch, x_ch, z_ch;
    ncc_pkg::sector_t            sec;
    r = '0;
    r.out_x = item.pos_x;
    r.out_y = item.pos_y;
    r.out_z = item.pos_z;
    pt[0] = item.coord_a;
    pt[1] = item.coord_b;
    pt[2] = item.coord_c;
    n = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
    if (n == 0) begin
      r.no_centroid = 1'b1;
      return r;
    end
    best = 0;
    best_dist = 0;
    for (int i = 0; i < n; i++) begin
      sq_dist = 0;
      for (int j = 0; j < 3; j++) begin
        diff = (pt[j] > centroid_tab[i][j]) ? pt[j] - centroid_tab[i][j]
                                            : centroid_tab[i][j] - pt[j];
        sq_dist += diff * diff;
      end
      if (i == 0 || sq_dist < best_dist) begin
        best = i;
        best_dist = sq_dist;
      end
    end
    s = (sat_reg > ncc_pkg::PCT_MAX) ? 100 : sat_reg;
    v = (bright_reg > ncc_pkg::PCT_MAX) ? 100 : bright_reg;
    hue = 360 / (best + 1);
    t = hue % 120;
    k = 60 - ((t > 60) ? t - 60 : 60 - t);
    pc = 60 * s * v;
    px = k * s * v;
    pm = 60 * v * (100 - s);
    c_ch = scale_channel(pc, pm);
    x_ch = scale_channel(px, pm);
    z_ch = scale_channel(0, pm);
    sec = (hue >= 300) ? ncc_pkg::SEC_MAG_RED : ncc_pkg::sector_t'(hue / 60);
    case (sec)
      ncc_pkg::SEC_RED_YEL: {r.red, r.green, r.blue} = {c_ch, x_ch, z_ch};
      ncc_pkg::SEC_YEL_GRN: {r.red, r.green, r.blue} = {x_ch, c_ch, z_ch};
      ncc_pkg::SEC_GRN_CYN: {r.red, r.green, r.blue} = {z_ch, c_ch, x_ch};
      ncc_pkg::SEC_CYN_BLU: {r.red, r.green, r.blue} = {z_ch, x_ch, c_ch};
      ncc_pkg::SEC_BLU_MAG: {r.red, r.green, r.blue} = {x_ch, z_ch, c_ch};
      default:              {r.red, r.green, r.blue} = {c_ch, z_ch, x_ch};
    endcase
    r.cluster = best[ncc_pkg::CL_W-1:0];
    return r;
  endfunction

  function automatic ncc_pkg::in_t make_item(logic action,
                                             logic [ncc_pkg::SLOT_W-1:0] slot,
                                             logic [ncc_pkg::COORD_W-1:0] a,
                                             logic [ncc_pkg::COORD_W-1:0] b,
                                             logic [ncc_pkg::COORD_W-1:0] c);
    ncc_pkg::in_t item;
    item.action  = action;
    item.slot    = slot;
    item.coord_a = a;
    item.coord_b = b;
    item.coord_c = c;
    item.pos_x   = $urandom();
    item.pos_y   = $urandom();
    item.pos_z   = $urandom();
    return item;
  endfunction

  function automatic logic [ncc_pkg::COORD_W-1:0] random_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ncc_pkg::COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [ncc_pkg::COORD_W-1:0] near_coord(
      logic [ncc_pkg::COORD_W-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 512)) - 256;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return ncc_pkg::COORD_W'(v);
  endfunction

  function automatic logic [ncc_pkg::PCT_W-1:0] random_percent();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ncc_pkg::PCT_MAX;
      2: return ncc_pkg::PCT_W'($urandom_range(101, 127));
      default: return ncc_pkg::PCT_W'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic ncc_pkg::in_t random_item();
    ncc_pkg::in_t item;
    int unsigned  pick, tgt;
    pick = $urandom_range(0, 99);
    tgt = $urandom_range(0, NUM_SLOTS - 1);
    item = make_item(ncc_pkg::ACT_CLASSIFY, ncc_pkg::SLOT_W'($urandom()), random_coord(),
                     random_coord(), random_coord());
    if (pick < 20) begin
      item.action = ncc_pkg::ACT_LOAD;
    end else if (pick < 25) begin
      item.action  = ncc_pkg::ACT_LOAD;
      item.coord_a = centroid_tab[tgt][0];
      item.coord_b = centroid_tab[tgt][1];
      item.coord_c = centroid_tab[tgt][2];
    end else if (pick < 70) begin
      item.coord_a = near_coord(centroid_tab[tgt][0]);
      item.coord_b = near_coord(centroid_tab[tgt][1]);
      item.coord_c = near_coord(centroid_tab[tgt][2]);
    end
    return item;
  endfunction

  task automatic send_item(input ncc_pkg::in_t item);
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    if (item.action == ncc_pkg::ACT_LOAD) begin
      centroid_tab[item.slot][0] = item.coord_a;
      centroid_tab[item.slot][1] = item.coord_b;
      centroid_tab[item.slot][2] = item.coord_c;
    end else begin
      pending_colors.insert(pending_colors.size(), classify_point(item));
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(input logic [ncc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ncc_pkg::PCT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ncc_pkg::REG_COUNT:      count_reg = value[ncc_pkg::CNT_W-1:0];
      ncc_pkg::REG_SATURATION: sat_reg = value;
      ncc_pkg::REG_BRIGHTNESS: bright_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [ncc_pkg::PCT_W-1:0] count,
                            input logic [ncc_pkg::PCT_W-1:0] sat,
                            input logic [ncc_pkg::PCT_W-1:0] bright);
    settle_block();
    write_register(ncc_pkg::REG_COUNT, count);
    write_register(ncc_pkg::REG_SATURATION, sat);
    write_register(ncc_pkg::REG_BRIGHTNESS, bright);
  endtask

  task automatic classify_at(input int unsigned slot);
    send_item(make_item(ncc_pkg::ACT_CLASSIFY, ncc_pkg::SLOT_W'($urandom()),
                        centroid_tab[slot][0], centroid_tab[slot][1],
                        centroid_tab[slot][2]));
  endtask

  task automatic test_no_centroid();
    ncc_pkg::in_t item;
    item = '0;
    item.action = ncc_pkg::ACT_CLASSIFY;
    send_item(item);
    item = '1;
    send_item(item);
  endtask

  task automatic test_nearest_search();
    ncc_pkg::in_t item;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      item = make_item(ncc_pkg::ACT_LOAD, ncc_pkg::SLOT_W'(i),
                       ncc_pkg::COORD_W'(i * 16'h2000), ncc_pkg::COORD_W'(i * 16'h1c00),
                       ncc_pkg::COORD_W'(i * 16'h2400));
      if (i == NUM_SLOTS - 1) begin
        item.coord_a = '1;
        item.coord_b = '1;
        item.coord_c = '1;
      end
      send_item(item);
    end
    set_config(ncc_pkg::PCT_W'(NUM_SLOTS), ncc_pkg::PCT_MAX, ncc_pkg::PCT_MAX);
    for (int i = 0; i < NUM_SLOTS; i++) classify_at(i);
    // Two slots at the same distance: the lower index must win.
    send_item(make_item(ncc_pkg::ACT_LOAD, 3'd2, centroid_tab[1][0], centroid_tab[1][1],
                        centroid_tab[1][2]));
    classify_at(1);
  endtask

  task automatic test_palette_extremes();
    set_config(ncc_pkg::PCT_W'(NUM_SLOTS), 7'd0, ncc_pkg::PCT_MAX);
    classify_at(3);
    set_config(ncc_pkg::PCT_W'(NUM_SLOTS), ncc_pkg::PCT_MAX, 7'd0);
    classify_at(5);
    set_config(7'd15, 7'd127, 7'd101);
    classify_at(7);
    classify_at(0);
    set_config(7'd1, 7'd50, 7'd50);
    classify_at(7);
    set_config(7'h70, ncc_pkg::PCT_MAX, ncc_pkg::PCT_MAX);
    classify_at(4);
  endtask

  task automatic test_random_traffic();
    int unsigned burst;
    burst = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(ncc_pkg::PCT_W'(NUM_SLOTS), ncc_pkg::PCT_MAX, ncc_pkg::PCT_MAX);
        1: set_config(7'd15, 7'd0, 7'd127);
        2: set_config(7'd3, 7'd127, 7'd0);
        default: set_config(ncc_pkg::PCT_W'($urandom_range(0, 127)), random_percent(),
                            random_percent());
      endcase
      repeat (125) begin
        if (burst == 0) begin
          burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 12);
          idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(5, 18)
                                                  : $urandom_range(0, 4));
        end
        burst--;
        send_item(random_item());
      end
    end
  endtask

  always @(posedge clk) begin : color_check
    ncc_pkg::out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: unexpected result %p", $time, out_data);
      end else begin
        want = pending_colors.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue || out_data.cluster !== want.cluster ||
            out_data.no_centroid !== want.no_centroid || out_data.out_x !== want.out_x ||
            out_data.out_y !== want.out_y || out_data.out_z !== want.out_z) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch, expected %p, got %p", $time, want, out_data);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_centroid();
    test_nearest_search();
    test_palette_extremes();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
